// ===== rtl/core/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: command codes,
// sequencer states, command and result records.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam logic [15:0] BLANK_CELL = 16'h0F20;
  localparam logic [7:0]  CHAR_LF    = 8'd10;
  localparam logic [7:0]  CHAR_CR    = 8'd13;

  typedef enum logic [1:0] {
    KIND_PUT   = 2'd0,
    KIND_CARET = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_NORM   = 2'd1,
    ST_SCROLL = 2'd2,
    ST_FILL   = 2'd3
  } state_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] char_code;
    logic [7:0] color;
    logic [6:0] column;
    logic [4:0] row;
  } tcw_in_t;

  typedef struct packed {
    logic [6:0]  caret_column;
    logic [4:0]  caret_row;
    logic [15:0] cell_value;
  } tcw_out_t;

endpackage

`default_nettype wire

// ===== rtl/core/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer
// Text screen of 16-bit cells (character low byte, color high byte) with a
// caret; put character, set caret, clear screen and read cell commands.
// ----------------------------------------------------------------------------
//
//  channel  ports                   handshake
//  -------  ----------------------  -------------------------------------
//  command  start, busy, in_data    transfer when start high, busy low
//  result   out_valid, out_data     one-cycle strobe, always taken
//
//  plain write, newline, carriage return, read cell: result in the cycle after
//  the transfer, busy stays low, a new command may follow every cycle.
//  set caret: busy in ST_NORM, which takes COLUMNS off the column and steps
//  the row while it runs on. scroll (write past the last cell, newline on the
//  bottom row): busy high, one cell moved per cycle, then the bottom row
//  blanked; clear screen blanks every cell, and so does reset, with no result.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire tcw_in_t  in_data,
  output logic          out_valid,
  output tcw_out_t      out_data
);

  localparam int CELLS       = COLUMNS * ROWS;
  localparam int AW          = $clog2(CELLS);
  localparam int CW          = $clog2(COLUMNS);
  localparam int RW          = $clog2(ROWS);
  localparam int SCROLL_LAST = CELLS - COLUMNS;

  state_t         state_r, state_nxt;
  logic [CW-1:0]  col_r, col_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic [7:0]     norm_col_r, norm_col_nxt;
  logic [7:0]     norm_row_r, norm_row_nxt;
  logic [AW-1:0]  ptr_r, ptr_nxt;
  logic           pend_r, pend_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_rd_r, out_rd_nxt;

  logic           we;
  logic [AW-1:0]  waddr, raddr;
  logic [15:0]    wdata, rdata;

  logic           accept;
  logic           last_col, last_row;
  logic           is_lf, is_cr;
  logic           needs_scroll;
  logic [AW-1:0]  caret_addr;
  logic [15:0]    read_lin;
  logic [AW-1:0]  read_addr;
  logic           norm_col_over, norm_row_over;
  logic [31:0]    col_ext, row_ext;

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  assign last_col   = (32'(col_r) == COLUMNS - 1);
  assign last_row   = (32'(row_r) == ROWS - 1);
  assign is_lf      = (in_data.char_code == CHAR_LF);
  assign is_cr      = (in_data.char_code == CHAR_CR);
  assign caret_addr = AW'(32'(row_r) * COLUMNS + 32'(col_r));

  // a newline or a write at the last cell runs off the bottom row
  assign needs_scroll = (in_data.kind == KIND_PUT) && !is_cr && last_row &&
                        (is_lf || last_col);

  assign read_lin  = 16'(in_data.column) + 16'(in_data.row) * 16'(COLUMNS);
  assign read_addr = (32'(read_lin) > CELLS - 1) ? AW'(CELLS - 1) : AW'(read_lin);

  assign norm_col_over = ({1'b0, norm_col_r} >= 9'(COLUMNS));
  assign norm_row_over = ({1'b0, norm_row_r} >= 9'(ROWS));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.kind)
            KIND_CARET: state_nxt = ST_NORM;
            KIND_CLEAR: state_nxt = ST_FILL;
            KIND_PUT:   state_nxt = needs_scroll ? ST_SCROLL : ST_IDLE;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_NORM: begin
        if (!norm_col_over) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCROLL: begin
        if (ptr_r == AW'(SCROLL_LAST)) begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        if (ptr_r == AW'(CELLS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory port
  always_comb begin
    col_nxt       = col_r;
    row_nxt       = row_r;
    norm_col_nxt  = norm_col_r;
    norm_row_nxt  = norm_row_r;
    ptr_nxt       = ptr_r;
    pend_nxt      = pend_r;
    out_valid_nxt = 1'b0;
    out_rd_nxt    = out_rd_r;
    we            = 1'b0;
    waddr         = caret_addr;
    wdata         = {in_data.color, in_data.char_code};
    raddr         = read_addr;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_rd_nxt = (in_data.kind == KIND_READ);
          case (in_data.kind)
            KIND_PUT: begin
              if (is_cr) begin
                col_nxt = '0;
              end else if (is_lf) begin
                col_nxt = '0;
                if (!last_row) begin
                  row_nxt = row_r + 1'b1;
                end
              end else begin
                we = 1'b1;
                if (!last_col) begin
                  col_nxt = col_r + 1'b1;
                end else begin
                  col_nxt = '0;
                  if (!last_row) begin
                    row_nxt = row_r + 1'b1;
                  end
                end
              end
              if (needs_scroll) begin
                ptr_nxt  = '0;
                pend_nxt = 1'b1;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            KIND_CARET: begin
              norm_col_nxt = {1'b0, in_data.column};
              norm_row_nxt = {3'b000, in_data.row};
            end
            KIND_CLEAR: begin
              col_nxt  = '0;
              row_nxt  = '0;
              ptr_nxt  = '0;
              pend_nxt = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_NORM: begin
        // column past the row width runs on into the following rows
        if (norm_col_over) begin
          norm_col_nxt = 8'({1'b0, norm_col_r} - 9'(COLUMNS));
          norm_row_nxt = norm_row_r + 8'd1;
        end else begin
          out_valid_nxt = 1'b1;
          if (norm_row_over) begin
            col_nxt = CW'(COLUMNS - 1);
            row_nxt = RW'(ROWS - 1);
          end else begin
            col_nxt = CW'(norm_col_r);
            row_nxt = RW'(norm_row_r);
          end
        end
      end
      ST_SCROLL: begin
        // read one row below, write back what the previous cycle read
        raddr = AW'(32'(ptr_r) + COLUMNS);
        we    = (ptr_r != '0);
        waddr = ptr_r - 1'b1;
        wdata = rdata;
        if (ptr_r != AW'(SCROLL_LAST)) begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      ST_FILL: begin
        we    = 1'b1;
        waddr = ptr_r;
        wdata = BLANK_CELL;
        if (ptr_r == AW'(CELLS - 1)) begin
          out_valid_nxt = pend_r;
          pend_nxt      = 1'b0;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      col_r       <= '0;
      row_r       <= '0;
      ptr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_rd_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      ptr_r       <= ptr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      out_rd_r    <= out_rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    norm_col_r <= norm_col_nxt;
    norm_row_r <= norm_row_nxt;
  end

  // caret fields are cut to the result widths
  assign col_ext = 32'(col_r);
  assign row_ext = 32'(row_r);

  assign out_valid               = out_valid_r;
  assign out_data.caret_column   = col_ext[6:0];
  assign out_data.caret_row      = row_ext[4:0];
  assign out_data.cell_value     = out_rd_r ? rdata : 16'h0000;

endmodule

`default_nettype wire

// ===== rtl/core/tcw_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
